// File: src/htfc_pkg.sv
// Shared types and codes for the humidity/temperature frame check filter.
// No dependencies; imported by htfc_convert and the top level.
`timescale 1ns / 1ps

package htfc_pkg;

   // Readout outcome as reported on the result stream
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BUS_FAIL = 2'd1,
      STATUS_CRC_FAIL = 2'd2
   } status_type;

   // One sensor readout as it arrives on the input stream
   typedef struct packed {
      logic [7:0] temp_high_byte;
      logic [7:0] temp_low_byte;
      logic [7:0] temp_check_byte;
      logic [7:0] hum_high_byte;
      logic [7:0] hum_low_byte;
      logic [7:0] hum_check_byte;
      logic       read_ok;
      logic       probe_ok;
   } frame_type;

   // Checked and converted sample, whole degrees and whole percent
   typedef struct packed {
      status_type status;
      logic       probe_ok;
      logic [7:0] temp_deg;
      logic [6:0] hum_pct;
   } sample_type;

endpackage

// File: src/htfc_convert.sv
// Frame check and unit conversion: CRC-8 on both words, scaling to hundredths,
// then rounding to whole units. Two register stages; depends on htfc_pkg.
`timescale 1ns / 1ps

module htfc_convert import htfc_pkg::*; (
   input  logic       clock,
   input  logic       enable,
   input  frame_type  frame,
   output sample_type sample
);

   localparam logic [7:0]  CRC_INIT    = 8'hFF;
   localparam logic [7:0]  CRC_POLY    = 8'h31;
   localparam logic [14:0] TEMP_SCALE  = 15'd17500;
   localparam logic [13:0] HUM_SCALE   = 14'd10000;
   localparam logic [15:0] TEMP_OFFSET = 16'd4500;
   localparam logic [13:0] ROUND_HALF  = 14'd50;
   // floor(n / 100) == (n * 5243) >> 19 for n below 43699
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   typedef struct packed {
      status_type  status;
      logic        probe_ok;
      logic [13:0] temp_round;
      logic [13:0] hum_round;
   } cent_type;

   function automatic logic [7:0] crc8_word(input logic [15:0] word);
      logic [7:0] crc;
      crc = CRC_INIT ^ word[15:8];
      for (int b = 0; b < 16; b++) begin
         if (b == 8) begin
            crc = crc ^ word[7:0];
         end
         crc = crc[7] ? ({crc[6:0], 1'b0} ^ CRC_POLY) : {crc[6:0], 1'b0};
      end
      return crc;
   endfunction

   // Divide by 65535: prod = a*65536 + b = a*65535 + (a + b), and a + b < 2*65535
   function automatic logic [15:0] div_65535(input logic [31:0] prod);
      logic [16:0] fold;
      fold = {1'b0, prod[31:16]} + {1'b0, prod[15:0]};
      return prod[31:16] + 16'(fold >= 17'd65535);
   endfunction

   logic [31:0] temp_prod;
   logic [31:0] hum_prod;
   logic [15:0] temp_q;
   logic [15:0] hum_q;
   logic [13:0] temp_cent;
   logic        crc_good;
   cent_type    cent_in;
   cent_type    cent_ff;
   logic [26:0] temp_div;
   logic [26:0] hum_div;
   sample_type  sample_in;
   sample_type  sample_ff;

   // stage 1: check and scale to hundredths
   always_comb begin
      temp_prod = 32'({frame.temp_high_byte, frame.temp_low_byte}) * 32'(TEMP_SCALE);
      hum_prod  = 32'({frame.hum_high_byte, frame.hum_low_byte}) * 32'(HUM_SCALE);
      temp_q    = div_65535(temp_prod);
      hum_q     = div_65535(hum_prod);
      // clamp negative temperatures at zero
      temp_cent = (temp_q < TEMP_OFFSET) ? 14'd0 : 14'(temp_q - TEMP_OFFSET);
      crc_good  = (crc8_word({frame.temp_high_byte, frame.temp_low_byte})
                   == frame.temp_check_byte)
               && (crc8_word({frame.hum_high_byte, frame.hum_low_byte})
                   == frame.hum_check_byte);

      cent_in.probe_ok   = frame.probe_ok;
      cent_in.temp_round = temp_cent + ROUND_HALF;
      cent_in.hum_round  = 14'(hum_q) + ROUND_HALF;
      if (!frame.read_ok) begin
         cent_in.status = STATUS_BUS_FAIL;
      end else if (!crc_good) begin
         cent_in.status = STATUS_CRC_FAIL;
      end else begin
         cent_in.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cent_ff <= cent_in;
      end
   end

   // stage 2: round to whole units
   always_comb begin
      temp_div           = 27'(cent_ff.temp_round) * 27'(RECIP_100);
      hum_div            = 27'(cent_ff.hum_round) * 27'(RECIP_100);
      sample_in.status   = cent_ff.status;
      sample_in.probe_ok = cent_ff.probe_ok;
      sample_in.temp_deg = temp_div[RECIP_SHIFT +: 8];
      sample_in.hum_pct  = hum_div[RECIP_SHIFT +: 7];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sample_ff <= sample_in;
      end
   end

   assign sample = sample_ff;

endmodule

// File: src/humidity_temp_frame_check_filter.sv
// Top level of the humidity/temperature frame check filter: stream ports,
// pipeline control and the two moving averages. Depends on htfc_pkg, htfc_convert.
`timescale 1ns / 1ps

// One readout in, one result out, one item per cycle. An item passes four
// registers (input, hundredths, whole units, result) before its result is
// offered. When the result register is full and not taken, the whole pipeline
// holds and req_tready drops in the same cycle. The first good readout loads
// the averages; later good readouts move each average a fifth of the way
// toward the sample. Failed readouts leave the averages untouched and report
// bus failure or CRC mismatch in status.
module humidity_temp_frame_check_filter import htfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] temp_high_byte, [15:8] temp_low_byte, [23:16] temp_check_byte,
   // [31:24] hum_high_byte, [39:32] hum_low_byte, [47:40] hum_check_byte,
   // [48] read_ok, [49] probe_ok, [55:50] zero
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] temperature, [14:8] humidity, [15] reading_valid,
   // [16] device_present, [18:17] status, [23:19] zero
   output logic [23:0] rsp_tdata
);

   localparam logic [15:0] RECIP_5 = 16'd205;   // floor(n / 5) == (n * 205) >> 10
   localparam int          RECIP_5_SHIFT = 10;

   // avg + (sample - avg) / 5, quotient truncated toward zero
   function automatic logic [7:0] smooth(input logic [7:0] avg, input logic [7:0] smp);
      logic [8:0]  diff;
      logic [7:0]  mag;
      logic [15:0] prod;
      logic [7:0]  step;
      diff = {1'b0, smp} - {1'b0, avg};
      mag  = diff[8] ? 8'(-diff) : diff[7:0];
      prod = 16'(mag) * RECIP_5;
      step = 8'(prod[15:RECIP_5_SHIFT]);
      return diff[8] ? (avg - step) : (avg + step);
   endfunction

   logic       advance;
   logic       in_valid_ff;
   frame_type  frame_ff;
   logic       s1_valid_ff;
   logic       s2_valid_ff;
   sample_type sample;

   logic       primed_ff,   primed_in;
   logic [7:0] temp_avg_ff, temp_avg_in;
   logic [6:0] hum_avg_ff,  hum_avg_in;

   logic       rsp_valid_ff;
   logic [7:0] temp_out_in;
   logic [6:0] hum_out_in;
   logic       good_in;
   logic       present_in;
   logic [7:0] temp_out_ff;
   logic [6:0] hum_out_ff;
   logic       good_ff;
   logic       present_ff;
   status_type status_ff;

   // hold every stage while the result waits
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff  <= req_tvalid;
         s1_valid_ff  <= in_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_tvalid) begin
         frame_ff.temp_high_byte  <= req_tdata[7:0];
         frame_ff.temp_low_byte   <= req_tdata[15:8];
         frame_ff.temp_check_byte <= req_tdata[23:16];
         frame_ff.hum_high_byte   <= req_tdata[31:24];
         frame_ff.hum_low_byte    <= req_tdata[39:32];
         frame_ff.hum_check_byte  <= req_tdata[47:40];
         frame_ff.read_ok         <= req_tdata[48];
         frame_ff.probe_ok        <= req_tdata[49];
      end
   end

   htfc_convert u_convert (
      .clock  (clock),
      .enable (advance),
      .frame  (frame_ff),
      .sample (sample)
   );

   // filter update on a good readout, hold otherwise
   always_comb begin
      primed_in   = primed_ff;
      temp_avg_in = temp_avg_ff;
      hum_avg_in  = hum_avg_ff;
      good_in     = (sample.status == STATUS_OK);
      present_in  = good_in || sample.probe_ok;
      if (good_in) begin
         primed_in = 1'b1;
         if (!primed_ff) begin
            temp_avg_in = sample.temp_deg;
            hum_avg_in  = sample.hum_pct;
         end else begin
            temp_avg_in = smooth(temp_avg_ff, sample.temp_deg);
            hum_avg_in  = 7'(smooth({1'b0, hum_avg_ff}, {1'b0, sample.hum_pct}));
         end
      end
      temp_out_in = temp_avg_in;
      hum_out_in  = hum_avg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff   <= 1'b0;
         temp_avg_ff <= '0;
         hum_avg_ff  <= '0;
      end else if (advance && s2_valid_ff) begin
         primed_ff   <= primed_in;
         temp_avg_ff <= temp_avg_in;
         hum_avg_ff  <= hum_avg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s2_valid_ff) begin
         temp_out_ff <= temp_out_in;
         hum_out_ff  <= hum_out_in;
         good_ff     <= good_in;
         present_ff  <= present_in;
         status_ff   <= sample.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, status_ff, present_ff, good_ff, hum_out_ff, temp_out_ff};

endmodule
